@@ src/cse_pkg.sv @@
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants for the CIR root path stepper
// Fixed-point formats, register indexes, sequencer states and the divider
// request and response groups.
// ----------------------------------------------------------------------------
package cse_pkg;

   // path store
   localparam int MAX_PATHS = 1024;
   localparam int SLOT_W    = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;

   // field widths
   localparam int PATH_W  = 10;
   localparam int SHOCK_W = 16;
   localparam int WORD_W  = 32;
   localparam int IROOT_W = 31;

   // fixed-point fractions
   localparam int Q_FRAC     = 24;
   localparam int SHOCK_FRAC = 12;

   // divider: 33 quotient bits, anything above is flagged as overflow
   localparam int QUOT_W    = WORD_W + 1;
   localparam int DIV_STEPS = QUOT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // shared multiplier: 33 x 33 signed
   localparam int MUL_W  = WORD_W + 1;
   localparam int PROD_W = 2 * MUL_W;

   // configuration register indexes
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIFT_TERM   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULL_TERM    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_GAIN   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_ROOT = 8'd3;

   // saturation limits
   localparam logic signed [WORD_W-1:0] S32_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] S32_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SETUP,
      ST_DIV,
      ST_MUL_B,
      ST_MUL_C,
      ST_SUM,
      ST_SQR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] num;
      logic [WORD_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic              ovf;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

@@ src/cse_div.sv @@
// ----------------------------------------------------------------------------
// cse_div: radix-2 restoring divider for the drift quotient
// Computes (num * 2^24) / den on magnitudes, one quotient bit per cycle.
// Quotients of 2^33 or more are reported through ovf.
// ----------------------------------------------------------------------------
module cse_div (
   input  logic                 clock,
   input  logic                 reset,
   input  cse_pkg::div_req_type div_req,
   output cse_pkg::div_rsp_type div_rsp
);
   import cse_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [WORD_W-1:0]    rem_ff;
   logic [WORD_W-1:0]    den_ff;
   logic [QUOT_W-1:0]    dsh_ff;
   logic [QUOT_W-1:0]    quot_ff;
   logic                 ovf_ff;

   logic [WORD_W:0]      shifted;
   logic [WORD_W:0]      trial;
   logic                 ge;

   // one trial subtraction per step
   assign shifted = {rem_ff, dsh_ff[QUOT_W-1]};
   assign ge      = (shifted >= {1'b0, den_ff});
   assign trial   = shifted - {1'b0, den_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: dividend is num shifted up by Q_FRAC bits
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff  <= {{(WORD_W-(WORD_W-9)){1'b0}}, div_req.num[WORD_W-1:9]};
         dsh_ff  <= {div_req.num[8:0], {Q_FRAC{1'b0}}};
         den_ff  <= div_req.den;
         quot_ff <= '0;
         // q >= 2^33 exactly when num >= den * 2^9
         ovf_ff  <= ({9'b0, div_req.num} >= {div_req.den, 9'b0});
      end else if (busy_ff) begin
         rem_ff  <= ge ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];
         dsh_ff  <= {dsh_ff[QUOT_W-2:0], 1'b0};
         quot_ff <= {quot_ff[QUOT_W-2:0], ge};
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.ovf  = ovf_ff;
   assign div_rsp.quot = quot_ff;

endmodule

@@ src/cir_sqrt_euler_path_step_top.sv @@
// ----------------------------------------------------------------------------
// cir_sqrt_euler_path_step_top: Euler stepper for CIR short-rate paths
// Advances one path's square root per item and returns the new rate.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration writes go over the csr_ channel (index 0 drift term,
//   1 pull term, 2 noise gain, 3 initial root); csr_ready is always high.
//   Write them while no item is in flight.
//   Each req_ item carries path index and shock in req_tdata and the restart
//   flag in req_tuser. The block reads the path root (or the initial root on
//   restart), forms y + A/y - B*y + C*shock, stores it and returns the
//   root, its square as rate and a fault flag on rsp_.
//   From acceptance to rsp_tvalid an item passes the root memory read, a
//   setup step, the bit-serial divider (33 quotient steps and its done
//   strobe), then the shared 33x33 multiplier, the final sum and the square.
//   A zero root skips the divider. One item is in work at a time: a new
//   item is accepted only once the last one has left the sequencer.
//   Results sit in an output register; the next item is accepted while a
//   result waits. If the receiver stalls, the following result holds in the
//   last sequencer step until the output register frees up.
//   Reset clears the configuration registers, the sequencer state and the
//   handshake state; the path memory is not cleared, so each path must start with restart set.
// ----------------------------------------------------------------------------
module cir_sqrt_euler_path_step_top (
   input  logic        clock,
   input  logic        reset,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [9:0] path_index, [25:10] shock, [31:26] zero
   input  logic        req_tuser,   // [0] restart
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [9:0] out_path, [41:10] rate, [73:42] root,
                                    // [79:74] zero
   output logic        rsp_tuser    // [0] fault
);
   import cse_pkg::*;

   // configuration registers
   logic signed [WORD_W-1:0] drift_ff;
   logic signed [WORD_W-1:0] pull_ff;
   logic signed [WORD_W-1:0] gain_ff;
   logic [IROOT_W-1:0]       iroot_ff;

   // sequencer
   state_type state_ff;
   state_type state_in;

   // item registers
   logic [PATH_W-1:0]         path_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic signed [SHOCK_W-1:0] shock_ff;
   logic                      restart_ff;
   logic                      fault_ff;
   logic signed [WORD_W-1:0]  y_ff;
   logic signed [WORD_W-1:0]  q_ff;
   logic signed [41:0]        bt_ff;
   logic signed [WORD_W-1:0]  ny_ff;
   logic                      neg_ff;

   // path root memory
   logic signed [WORD_W-1:0] path_roots [MAX_PATHS];
   logic signed [WORD_W-1:0] rd_data_ff;
   logic [SLOT_W-1:0]        req_slot;

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod_ff;

   // output register
   logic              rsp_valid_ff;
   logic [PATH_W-1:0] rsp_path_ff;
   logic [WORD_W-1:0] rsp_rate_ff;
   logic [WORD_W-1:0] rsp_root_ff;
   logic              rsp_fault_ff;

   // divider
   div_req_type div_req;
   div_rsp_type div_rsp;

   // datapath helpers
   logic               req_take;
   logic               rsp_load;
   logic [WORD_W-1:0]  y_mag;
   logic [WORD_W-1:0]  a_mag;
   logic [WORD_W-1:0]  ny_mag;
   logic signed [WORD_W-1:0] q_in;
   logic               q_clip;
   logic signed [35:0] ct;
   logic signed [43:0] sum;
   logic signed [WORD_W-1:0] ny_in;
   logic               ny_clip;
   logic [41:0]        sq;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign req_slot   = SLOT_W'(32'(req_tdata[PATH_W-1:0]) % MAX_PATHS);
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         drift_ff <= '0;
         pull_ff  <= '0;
         gain_ff  <= '0;
         iroot_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DRIFT_TERM:   drift_ff <= csr_data;
            CSR_PULL_TERM:    pull_ff  <= csr_data;
            CSR_NOISE_GAIN:   gain_ff  <= csr_data;
            CSR_INITIAL_ROOT: iroot_ff <= csr_data[IROOT_W-1:0];
            default: ;
         endcase
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and divider start
   always_comb begin
      state_in      = state_ff;
      div_req.start = 1'b0;
      div_req.num   = a_mag;
      div_req.den   = y_mag;
      unique case (state_ff)
         ST_IDLE:  if (req_take) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_SETUP;
         ST_SETUP: begin
            if (y_ff == '0) begin
               state_in = ST_MUL_B;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV:   if (div_rsp.done) state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_MUL_C;
         ST_MUL_C: state_in = ST_SUM;
         ST_SUM:   state_in = ST_SQR;
         ST_SQR:   state_in = ST_DONE;
         ST_DONE:  if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   cse_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // memory: registered read at acceptance, write of the new root
   always_ff @(posedge clock) begin
      rd_data_ff <= path_roots[req_slot];
      if (state_ff == ST_SUM) begin
         path_roots[slot_ff] <= ny_in;
      end
   end

   // magnitudes
   assign y_mag  = y_ff[WORD_W-1] ? WORD_W'(-y_ff) : WORD_W'(y_ff);
   assign a_mag  = drift_ff[WORD_W-1] ? WORD_W'(-drift_ff) : WORD_W'(drift_ff);
   assign ny_mag = ny_ff[WORD_W-1] ? WORD_W'(-ny_ff) : WORD_W'(ny_ff);

   // quotient clip: negative side reaches 2^31, positive side 2^31-1
   always_comb begin
      q_clip = div_rsp.ovf ||
               (div_rsp.quot > (neg_ff ? {2'b01, {(QUOT_W-2){1'b0}}}
                                       : {2'b00, {(QUOT_W-2){1'b1}}}));
      if (q_clip) begin
         q_in = neg_ff ? S32_MIN : S32_MAX;
      end else if (neg_ff) begin
         q_in = WORD_W'(-div_rsp.quot);
      end else begin
         q_in = div_rsp.quot[WORD_W-1:0];
      end
   end

   // shared multiplier operand select; the square is held while a result waits
   always_comb begin
      unique case (state_ff)
         ST_MUL_B: begin
            mul_a = MUL_W'(pull_ff);
            mul_b = MUL_W'(y_ff);
         end
         ST_MUL_C: begin
            mul_a = MUL_W'(gain_ff);
            mul_b = MUL_W'(shock_ff);
         end
         ST_SQR, ST_DONE: begin
            mul_a = {1'b0, ny_mag};
            mul_b = {1'b0, ny_mag};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // floor shifts are arithmetic right shifts of the product
   assign ct = prod_ff[47:SHOCK_FRAC];
   assign sum = 44'(y_ff) + 44'(q_ff) - 44'(bt_ff) + 44'(ct);

   // new root saturation
   always_comb begin
      ny_clip = (sum > 44'(S32_MAX)) || (sum < 44'(S32_MIN));
      if (sum > 44'(S32_MAX)) begin
         ny_in = S32_MAX;
      end else if (sum < 44'(S32_MIN)) begin
         ny_in = S32_MIN;
      end else begin
         ny_in = sum[WORD_W-1:0];
      end
   end

   assign sq = prod_ff[PROD_W-1:Q_FRAC];

   // item datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               path_ff    <= req_tdata[PATH_W-1:0];
               slot_ff    <= req_slot;
               shock_ff   <= req_tdata[PATH_W +: SHOCK_W];
               restart_ff <= req_tuser;
               fault_ff   <= 1'b0;
            end
         end
         ST_FETCH: begin
            y_ff <= restart_ff ? {1'b0, iroot_ff} : rd_data_ff;
         end
         ST_SETUP: begin
            neg_ff <= drift_ff[WORD_W-1] ^ y_ff[WORD_W-1];
            // zero divisor: saturate by the sign of the drift term, or zero for a zero drift term
            if (y_ff == '0) begin
               fault_ff <= 1'b1;
               if (drift_ff == '0) begin
                  q_ff <= '0;
               end else begin
                  q_ff <= drift_ff[WORD_W-1] ? S32_MIN : S32_MAX;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               q_ff <= q_in;
               if (q_clip) fault_ff <= 1'b1;
            end
         end
         ST_MUL_C: begin
            bt_ff <= prod_ff[PROD_W-1:Q_FRAC];
         end
         ST_SUM: begin
            ny_ff <= ny_in;
            if (ny_clip) fault_ff <= 1'b1;
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_path_ff  <= path_ff;
         rsp_root_ff  <= ny_ff;
         rsp_rate_ff  <= (|sq[41:WORD_W]) ? {WORD_W{1'b1}} : sq[WORD_W-1:0];
         rsp_fault_ff <= fault_ff || (|sq[41:WORD_W]);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_root_ff, rsp_rate_ff, rsp_path_ff};
   assign rsp_tuser  = rsp_fault_ff;

endmodule
